>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define CCT_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define CCT_ASSERT_NXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define CCT_ASSERT_IMP(lbl, clk, rstn, pre, post, msg)
`define CCT_ASSERT_NXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

>>> rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock package
// Date type, field limits and calendar helper functions.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DATA_W   = 40;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    // first member sits in the top bits, so hour lands in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
    } date_t;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
    localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    localparam date_t DATE_RESET = '{
        year:   14'd2000,
        month:  4'd1,
        day:    5'd1,
        second: 6'd0,
        minute: 6'd0,
        hour:   5'd0
    };

    // multiplicative inverse of 25 modulo 2^14 and the divisibility bound
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_BOUND = 14'd655;

    // leap: divisible by 400, or by 4 and not by 100
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] p;
        logic              div4;
        logic              div16;
        logic              div25;
        p     = y * INV25;
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (p <= DIV25_BOUND);
        return div4 && (div16 || !div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (mo)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/cct_next.sv
// ----------------------------------------------------------------------------
// Calendar clock next-state logic
// Advances the date by one second or range-checks and applies a load.
// ----------------------------------------------------------------------------
module cct_next #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  cct_pkg::func_t func,
    input  cct_pkg::date_t cur,
    input  cct_pkg::date_t set,
    output cct_pkg::date_t nxt,
    output logic           load_error
);
    import cct_pkg::*;

    localparam logic [YEAR_W-1:0] YEAR_LIM = YEAR_W'(YEAR_LIMIT);

    logic             load_ok;
    logic [DAY_W-1:0] set_len;
    logic [DAY_W-1:0] cur_len;
    date_t            tick_date;

    assign set_len = month_days(set.month, is_leap(set.year));
    assign cur_len = month_days(cur.month, is_leap(cur.year));

    assign load_ok = (set.hour <= HOUR_MAX) && (set.minute <= MINUTE_MAX) &&
                     (set.second <= SECOND_MAX) &&
                     (set.year != '0) && (set.year <= YEAR_LIM) &&
                     (set.month != '0) && (set.month <= MONTH_MAX) &&
                     (set.day != '0) && (set.day <= set_len);

    // cascaded rollover
    always_comb begin
        tick_date = cur;
        if (cur.second >= SECOND_MAX) begin
            tick_date.second = '0;
            if (cur.minute >= MINUTE_MAX) begin
                tick_date.minute = '0;
                if (cur.hour >= HOUR_MAX) begin
                    tick_date.hour = '0;
                    if (cur.day >= cur_len) begin
                        tick_date.day = 5'd1;
                        if (cur.month >= MONTH_MAX) begin
                            tick_date.month = MONTH_JAN;
                            if (cur.year >= YEAR_LIM) begin
                                tick_date.year = 14'd1;
                            end else begin
                                tick_date.year = cur.year + 14'd1;
                            end
                        end else begin
                            tick_date.month = cur.month + 4'd1;
                        end
                    end else begin
                        tick_date.day = cur.day + 5'd1;
                    end
                end else begin
                    tick_date.hour = cur.hour + 5'd1;
                end
            end else begin
                tick_date.minute = cur.minute + 6'd1;
            end
        end else begin
            tick_date.second = cur.second + 6'd1;
        end
    end

    always_comb begin
        unique case (func)
            FUNC_LOAD: begin
                nxt        = load_ok ? set : cur;
                load_error = !load_ok;
            end
            default: begin
                nxt        = tick_date;
                load_error = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/calendar_clock_tick.sv
// ----------------------------------------------------------------------------
// Calendar clock tick
// Real-time clock with Gregorian calendar: one-second ticks and checked loads.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                           tuser
// s_       in   hour,minute,second,day,mon,yr   func (0 tick, 1 load)
// m_       out  hour,minute,second,day,mon,yr   load_error
//
// One transaction per cycle sustained while m_tready stays high; a result is
// presented on m_ after passing the input register, then the result register.
// The clock state updates as the item leaves the input register.
// Reset sets the clock to 00:00:00 on 1 January 2000, no clearing pass.
// A stalled result holds while the input register still takes one more item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_clock_tick #(
    parameter int unsigned YEAR_LIMIT = 9999
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // hour[4:0] minute[10:5] second[16:11] day[21:17] month[25:22] year[39:26]
    input  logic [cct_pkg::DATA_W-1:0]   s_tdata,
    // func[0]
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // hour[4:0] minute[10:5] second[16:11] day[21:17] month[25:22] year[39:26]
    output logic [cct_pkg::DATA_W-1:0]   m_tdata,
    // load_error[0]
    output logic                         m_tuser
);
    import cct_pkg::*;

    localparam logic [YEAR_W-1:0] YEAR_LIM = YEAR_W'(YEAR_LIMIT);

    logic  in_valid_reg, in_valid_next;
    func_t in_func_reg;
    date_t in_set_reg;
    date_t clock_reg, clock_next;
    logic  out_valid_reg, out_valid_next;
    date_t out_date_reg;
    logic  out_err_reg;
    logic  err_next;
    logic  advance;
    logic  s_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    cct_next #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_next (
        .func       (in_func_reg),
        .cur        (clock_reg),
        .set        (in_set_reg),
        .nxt        (clock_next),
        .load_error (err_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clock_reg     <= DATE_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                clock_reg <= clock_next;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_func_reg <= func_t'(s_tuser);
            in_set_reg  <= date_t'(s_tdata);
        end
        if (advance) begin
            out_date_reg <= clock_next;
            out_err_reg  <= err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_date_reg;
    assign m_tuser  = out_err_reg;

    `CCT_ASSERT_IMP(a_clock_legal, aclk, aresetn, 1'b1,
        (clock_reg.hour <= HOUR_MAX) && (clock_reg.minute <= MINUTE_MAX) &&
        (clock_reg.second <= SECOND_MAX) && (clock_reg.month != '0) &&
        (clock_reg.month <= MONTH_MAX) && (clock_reg.day != '0) &&
        (clock_reg.year != '0) && (clock_reg.year <= YEAR_LIM),
        "clock state out of range")
    `CCT_ASSERT_NXT(a_tick_no_error, aclk, aresetn,
        advance && (in_func_reg == FUNC_TICK),
        !out_err_reg,
        "load error flagged on a tick")
    `CCT_ASSERT_NXT(a_reject_holds, aclk, aresetn,
        advance && err_next,
        $stable(clock_reg),
        "rejected load changed the clock")
    `CCT_ASSERT_NXT(a_second_step, aclk, aresetn,
        advance && (in_func_reg == FUNC_TICK) && (clock_reg.second < SECOND_MAX),
        clock_reg.second == $past(clock_reg.second) + 6'd1,
        "tick failed to advance the second")
    `CCT_ASSERT_NXT(a_idle_holds, aclk, aresetn,
        !advance,
        $stable(clock_reg),
        "clock changed with no item leaving the input register")

endmodule
